// ===== design/paft_pkg.sv =====
// Shared types and constants for the protected process id access filter table.
// Used by the controller, the datapath and the top level; depends on nothing.
package paft_pkg;

    localparam int PAFT_CAPACITY = 64;
    localparam int PAFT_WORD_W   = 32;

    localparam logic [1:0] FUNC_CHECK  = 2'd0;
    localparam logic [1:0] FUNC_ADD    = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;
    localparam logic [1:0] FUNC_CLEAR  = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;   // latch a new item and rewind the table scan
        logic step;    // advance the table scan by one entry
        logic commit;  // apply the update and load the result register
    } paft_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;  // the item at the input port has to search the table
        logic scan_done;  // the scan found the id or has passed the last entry
    } paft_stat_t;

endpackage

// ===== design/paft_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Holds the id and mask of each table slot; no dependencies.
module paft_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/paft_ctrl.sv =====
// Controller for the access filter table: sequences accept, table scan and commit.
// Depends on paft_pkg for the command and status structs.
module paft_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  paft_pkg::paft_stat_t stat,
    output paft_pkg::paft_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    assign cmd.start  = accept;
    assign cmd.step   = (state_reg == ST_SCAN);
    assign cmd.commit = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = stat.need_scan ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== design/paft_dpath.sv =====
// Datapath for the access filter table: item registers, valid bits, scan compare,
// update logic and result registers. Depends on paft_pkg and paft_ram.
module paft_dpath #(
    parameter int CAPACITY = paft_pkg::PAFT_CAPACITY,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  paft_pkg::paft_cmd_t  cmd,
    output paft_pkg::paft_stat_t stat,
    input  logic                cfg_we,
    input  logic                cfg_enable,
    input  logic [1:0]          func,
    input  logic [31:0]         process_id,
    input  logic [31:0]         exclude_bits,
    input  logic [31:0]         requested_access,
    input  logic                kernel_handle,
    input  logic                object_is_process,
    output logic [31:0]         granted_access,
    output logic                protected_hit,
    output logic [1:0]          status,
    output logic [CW-1:0]       entry_count
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DW = 2 * paft_pkg::PAFT_WORD_W;
    localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);

    // Control state.
    logic                enable_reg;
    logic [CAPACITY-1:0] entry_valid_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       rd_idx_reg;
    logic                cmp_pending_reg;
    logic                hit_reg;
    logic                free_found_reg;

    // Item and scan payload.
    logic [1:0]          func_reg;
    logic [31:0]         pid_reg;
    logic [31:0]         excl_reg;
    logic [31:0]         req_reg;
    logic                kern_reg;
    logic                isproc_reg;
    logic [IW-1:0]       cmp_idx_reg;
    logic [IW-1:0]       slot_reg;
    logic [IW-1:0]       free_idx_reg;
    logic [31:0]         mask_reg;

    // Result registers.
    logic [31:0]         granted_reg;
    logic                hit_out_reg;
    logic [1:0]          status_reg;
    logic [CW-1:0]       cnt_out_reg;

    logic [DW-1:0]       rdata;
    logic                cmp_match;
    logic                cur_valid;

    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    logic                set_valid;
    logic                clr_valid;
    logic                clear_all;
    logic                cnt_inc;
    logic                cnt_dec;
    logic [31:0]         granted_next;
    logic                hit_out_next;
    logic [1:0]          status_next;
    logic [CW-1:0]       count_next;

    paft_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata ({pid_reg, excl_reg}),
        .raddr (rd_idx_reg[IW-1:0]),
        .rdata (rdata)
    );

    assign cur_valid = entry_valid_reg[cmp_idx_reg];
    assign cmp_match = cmp_pending_reg && cur_valid
                       && (rdata[DW-1:paft_pkg::PAFT_WORD_W] == pid_reg);

    // A disabled table, a clear and a check on something other than a process skip the scan.
    assign stat.need_scan = enable_reg
                            && ((func == paft_pkg::FUNC_CHECK) ? object_is_process
                                                               : (func != paft_pkg::FUNC_CLEAR));

    assign stat.scan_done = cmp_match || ((rd_idx_reg == CAP_W) && !cmp_pending_reg);

    always_comb
    begin
        wr_en        = 1'b0;
        wr_addr      = slot_reg;
        set_valid    = 1'b0;
        clr_valid    = 1'b0;
        clear_all    = 1'b0;
        cnt_inc      = 1'b0;
        cnt_dec      = 1'b0;
        granted_next = '0;
        hit_out_next = 1'b0;
        status_next  = paft_pkg::STATUS_OK;
        unique case (func_reg)
            paft_pkg::FUNC_CHECK:
            begin
                // hit_reg can only be set when the table was enabled at acceptance and the target is a process.
                hit_out_next = hit_reg;
                granted_next = (hit_reg && !kern_reg) ? (req_reg & ~mask_reg) : req_reg;
            end
            paft_pkg::FUNC_ADD:
            begin
                if (enable_reg)
                begin
                    if (hit_reg)
                    begin
                        hit_out_next = 1'b1;
                        wr_en        = 1'b1;
                    end
                    else if (free_found_reg)
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = free_idx_reg;
                        set_valid = 1'b1;
                        cnt_inc   = 1'b1;
                    end
                    else
                    begin
                        status_next = paft_pkg::STATUS_FULL;
                    end
                end
            end
            paft_pkg::FUNC_REMOVE:
            begin
                if (enable_reg)
                begin
                    if (hit_reg)
                    begin
                        hit_out_next = 1'b1;
                        clr_valid    = 1'b1;
                        cnt_dec      = (count_reg != '0);
                    end
                    else
                    begin
                        status_next = paft_pkg::STATUS_NOT_FOUND;
                    end
                end
            end
            paft_pkg::FUNC_CLEAR:
            begin
                clear_all = enable_reg;
            end
            default:
            begin
                status_next = paft_pkg::STATUS_OK;
            end
        endcase
        wr_en     = wr_en && cmd.commit;
        set_valid = set_valid && cmd.commit;
        clr_valid = clr_valid && cmd.commit;
        clear_all = clear_all && cmd.commit;
        cnt_inc   = cnt_inc && cmd.commit;
        cnt_dec   = cnt_dec && cmd.commit;

        if (clear_all)
        begin
            count_next = '0;
        end
        else if (cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            entry_valid_reg <= '0;
            count_reg       <= '0;
            rd_idx_reg      <= '0;
            cmp_pending_reg <= 1'b0;
            hit_reg         <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                enable_reg <= cfg_enable;
            end
            count_reg <= count_next;
            if (clear_all)
            begin
                entry_valid_reg <= '0;
            end
            else if (set_valid)
            begin
                entry_valid_reg[free_idx_reg] <= 1'b1;
            end
            else if (clr_valid)
            begin
                entry_valid_reg[slot_reg] <= 1'b0;
            end

            if (cmd.start)
            begin
                rd_idx_reg      <= '0;
                cmp_pending_reg <= 1'b0;
                hit_reg         <= 1'b0;
                free_found_reg  <= 1'b0;
            end
            else if (cmd.step)
            begin
                if (rd_idx_reg != CAP_W)
                begin
                    rd_idx_reg      <= rd_idx_reg + CW'(1);
                    cmp_pending_reg <= 1'b1;
                end
                else
                begin
                    cmp_pending_reg <= 1'b0;
                end
                if (cmp_match)
                begin
                    hit_reg <= 1'b1;
                end
                // The lowest free slot is the first invalid entry the scan passes.
                if (cmp_pending_reg && !cur_valid && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            func_reg   <= func;
            pid_reg    <= process_id;
            excl_reg   <= exclude_bits;
            req_reg    <= requested_access;
            kern_reg   <= kernel_handle;
            isproc_reg <= object_is_process;
        end
        else if (cmd.step)
        begin
            if (rd_idx_reg != CAP_W)
            begin
                cmp_idx_reg <= rd_idx_reg[IW-1:0];
            end
            if (cmp_match)
            begin
                slot_reg <= cmp_idx_reg;
                mask_reg <= rdata[paft_pkg::PAFT_WORD_W-1:0];
            end
            if (cmp_pending_reg && !cur_valid && !free_found_reg)
            begin
                free_idx_reg <= cmp_idx_reg;
            end
        end
        if (cmd.commit)
        begin
            granted_reg <= granted_next;
            hit_out_reg <= hit_out_next;
            status_reg  <= status_next;
            cnt_out_reg <= count_next;
        end
    end

    assign granted_access = granted_reg;
    assign protected_hit  = hit_out_reg;
    assign status         = status_reg;
    assign entry_count    = cnt_out_reg;

    // The running count always equals the number of valid slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(entry_valid_reg) == int'(count_reg))
        else $error("entry count differs from the number of valid slots");

    // A new entry is only ever placed in a slot that is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        set_valid |-> !entry_valid_reg[free_idx_reg])
        else $error("add writes into a slot that is already valid");

    // The scan never runs past the end of the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_idx_reg <= CAP_W)
        else $error("table scan ran past the last slot");

    // A check only strips access for a process target of an enabled table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (func_reg == paft_pkg::FUNC_CHECK) && hit_reg)
            |-> (enable_reg && isproc_reg))
        else $error("check matched without an enabled table and a process target");

endmodule

// ===== design/pid_access_filter_table_unit.sv =====
// Top level of the protected process id access filter table.
// Depends on paft_pkg, paft_ctrl, paft_dpath and paft_ram.
//
//   Channel   Handshake              Carries
//   in        in_valid / in_ready    func, process_id, exclude_bits, requested_access,
//                                    kernel_handle, object_is_process
//   out       out_valid / out_ready  granted_access, protected_hit, status, entry_count
//   cfg       cfg_valid / cfg_ready  filter_enable
//
// An item that needs no lookup (disabled table, clear, check of a non-process object)
// goes from acceptance straight to the commit; one that searches the table first runs
// the scan, which reads one slot a cycle from the table RAM and stops at the first match
// or after the last slot.
// A new item is accepted in the cycle after the previous one has been committed to the
// result register, even while that result is still waiting on out_ready.
// Reset is asynchronous and active low; it empties the table and disables it.
module pid_access_filter_table_unit #(
    parameter int CAPACITY = paft_pkg::PAFT_CAPACITY,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    func,
    input  logic [31:0]   process_id,
    input  logic [31:0]   exclude_bits,
    input  logic [31:0]   requested_access,
    input  logic          kernel_handle,
    input  logic          object_is_process,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [31:0]   granted_access,
    output logic          protected_hit,
    output logic [1:0]    status,
    output logic [CW-1:0] entry_count,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          filter_enable
);

    paft_pkg::paft_cmd_t  cmd;
    paft_pkg::paft_stat_t stat;

    assign cfg_ready = 1'b1;

    paft_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    paft_dpath #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_enable        (filter_enable),
        .func              (func),
        .process_id        (process_id),
        .exclude_bits      (exclude_bits),
        .requested_access  (requested_access),
        .kernel_handle     (kernel_handle),
        .object_is_process (object_is_process),
        .granted_access    (granted_access),
        .protected_hit     (protected_hit),
        .status            (status),
        .entry_count       (entry_count)
    );

endmodule

// ===== bench/pid_access_filter_table_unit_tb.sv =====
// Self-checking testbench for pid_access_filter_table_unit: directed cases, then random
// add/remove/clear/check traffic with idle cycles on the input and backpressure on the output.
// Depends on paft_pkg and the RTL of the block; a scoreboard class predicts every result.
module pid_access_filter_table_unit_tb;

    localparam int CAP         = paft_pkg::PAFT_CAPACITY;
    localparam int CW          = $clog2(CAP + 1);
    localparam int ITEMS       = 1000;
    localparam int POOL        = 96;
    localparam int SETTLE      = CAP + 8;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct {
        logic [31:0]   granted;
        logic          hit;
        logic [1:0]    status;
        logic [CW-1:0] count;
    } filter_verdict_t;

    // Predicts the filter table and holds the results still owed by the block.
    class access_filter_scoreboard;
        bit              enabled;
        bit              slot_used [CAP];
        bit [31:0]       slot_pid [CAP];
        bit [31:0]       slot_mask [CAP];
        int              held;
        filter_verdict_t pending_verdicts [$];
        int              errors;
        int              results_seen;
        int              ops_seen [4];
        int              hits_seen;
        int              full_seen;
        int              missing_seen;

        function int lookup(bit [31:0] pid);
            for (int i = 0; i < CAP; i++)
            begin
                if (slot_used[i] && slot_pid[i] == pid)
                    return i;
            end
            return -1;
        endfunction

        function int free_slot();
            for (int i = 0; i < CAP; i++)
            begin
                if (!slot_used[i])
                    return i;
            end
            return -1;
        endfunction

        function void note_item(bit [1:0] op, bit [31:0] pid, bit [31:0] excl,
                                bit [31:0] req, bit kern, bit isproc);
            filter_verdict_t v;
            int              slot;
            v.granted = '0;
            v.hit     = 1'b0;
            v.status  = paft_pkg::STATUS_OK;
            ops_seen[op]++;
            if (op == paft_pkg::FUNC_CHECK)
            begin
                v.granted = req;
                if (enabled && isproc)
                begin
                    slot = lookup(pid);
                    if (slot >= 0)
                    begin
                        v.hit = 1'b1;
                        if (!kern)
                            v.granted = req & ~slot_mask[slot];
                    end
                end
            end
            else if (enabled)
            begin
                case (op)
                    paft_pkg::FUNC_ADD:
                    begin
                        slot = lookup(pid);
                        if (slot >= 0)
                        begin
                            v.hit = 1'b1;
                            slot_mask[slot] = excl;
                        end
                        else
                        begin
                            slot = free_slot();
                            if (slot < 0)
                                v.status = paft_pkg::STATUS_FULL;
                            else
                            begin
                                slot_used[slot] = 1'b1;
                                slot_pid[slot]  = pid;
                                slot_mask[slot] = excl;
                                held++;
                            end
                        end
                    end
                    paft_pkg::FUNC_REMOVE:
                    begin
                        slot = lookup(pid);
                        if (slot >= 0)
                        begin
                            v.hit = 1'b1;
                            slot_used[slot] = 1'b0;
                            held--;
                        end
                        else
                            v.status = paft_pkg::STATUS_NOT_FOUND;
                    end
                    default:
                    begin
                        for (int i = 0; i < CAP; i++)
                            slot_used[i] = 1'b0;
                        held = 0;
                    end
                endcase
            end
            v.count = CW'(held);
            hits_seen += v.hit;
            if (v.status == paft_pkg::STATUS_FULL)
                full_seen++;
            if (v.status == paft_pkg::STATUS_NOT_FOUND)
                missing_seen++;
            pending_verdicts.push_back(v);
        endfunction

        function void check_result(logic [31:0] granted, logic hit, logic [1:0] status,
                                   logic [CW-1:0] count);
            filter_verdict_t want;
            results_seen++;
            if (pending_verdicts.size() == 0)
            begin
                $error("result with no item outstanding: granted_access %h", granted);
                errors++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (granted !== want.granted)
            begin
                $error("granted_access: expected %h, got %h", want.granted, granted);
                errors++;
            end
            if (hit !== want.hit)
            begin
                $error("protected_hit: expected %0d, got %0d", want.hit, hit);
                errors++;
            end
            if (status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, status);
                errors++;
            end
            if (count !== want.count)
            begin
                $error("entry_count: expected %0d, got %0d", want.count, count);
                errors++;
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n             = 1'b0;
    logic          in_valid          = 1'b0;
    logic          in_ready;
    logic [1:0]    func              = paft_pkg::FUNC_CHECK;
    logic [31:0]   process_id        = '0;
    logic [31:0]   exclude_bits      = '0;
    logic [31:0]   requested_access  = '0;
    logic          kernel_handle     = 1'b0;
    logic          object_is_process = 1'b0;
    logic          out_valid;
    logic          out_ready         = 1'b0;
    logic [31:0]   granted_access;
    logic          protected_hit;
    logic [1:0]    status;
    logic [CW-1:0] entry_count;
    logic          cfg_valid         = 1'b0;
    logic          cfg_ready;
    logic          filter_enable     = 1'b0;

    access_filter_scoreboard board = new();
    bit          calm;
    int          hold_left;
    int          sent;
    int          cycle_count;
    int          cfg_writes;
    logic [31:0] id_pool [POOL];

    pid_access_filter_table_unit u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .func              (func),
        .process_id        (process_id),
        .exclude_bits      (exclude_bits),
        .requested_access  (requested_access),
        .kernel_handle     (kernel_handle),
        .object_is_process (object_is_process),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .granted_access    (granted_access),
        .protected_hit     (protected_hit),
        .status            (status),
        .entry_count       (entry_count),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .filter_enable     (filter_enable)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    // Mostly random words, with the all-zero and all-one masks mixed in.
    function automatic logic [31:0] pick_word();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return 32'h0;
        if (roll < 20)
            return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    task automatic send_item(logic [1:0] op, logic [31:0] pid, logic [31:0] excl,
                             logic [31:0] req, logic kern, logic isproc);
        @(negedge clk);
        if (!calm && chance(8))
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid          <= 1'b1;
        func              <= op;
        process_id        <= pid;
        exclude_bits      <= excl;
        requested_access  <= req;
        kernel_handle     <= kern;
        object_is_process <= isproc;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_item(op, pid, excl, req, kern, isproc);
        sent++;
    endtask

    task automatic in_stop();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (board.pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // The enable is only written with the block idle and nothing owed.
    task automatic set_filter(bit on);
        in_stop();
        wait_drained();
        @(negedge clk);
        cfg_valid     <= 1'b1;
        filter_enable <= on;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.enabled = on;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_mix(int n, int span, int pct_chk, int pct_add, int pct_rem);
        int          roll;
        logic [1:0]  op;
        logic [31:0] pid;
        for (int k = 0; k < n; k++)
        begin
            roll = $urandom_range(99);
            if (roll < pct_chk)
                op = paft_pkg::FUNC_CHECK;
            else if (roll < pct_chk + pct_add)
                op = paft_pkg::FUNC_ADD;
            else if (roll < pct_chk + pct_add + pct_rem)
                op = paft_pkg::FUNC_REMOVE;
            else
                op = paft_pkg::FUNC_CLEAR;
            pid = chance(8) ? $urandom() : id_pool[$urandom_range(span - 1)];
            send_item(op, pid, pick_word(), pick_word(), chance(20), chance(85));
        end
    endtask

    // Adding more distinct ids than there are slots drives the table into the full case.
    task automatic fill_table();
        for (int i = 0; i < CAP + 8; i++)
        begin
            send_item(paft_pkg::FUNC_ADD, id_pool[i], pick_word(), pick_word(), chance(20),
                      chance(85));
            if (chance(25))
                send_item(paft_pkg::FUNC_CHECK, id_pool[$urandom_range(POOL - 1)], pick_word(),
                          pick_word(), chance(20), 1'b1);
        end
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= calm || !chance(8);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(granted_access, protected_hit, status, entry_count);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int phase;
        id_pool[0] = 32'h0;
        id_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL; i++)
            id_pool[i] = $urandom();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // While disabled, updates are ignored and checks pass access through.
        send_item(paft_pkg::FUNC_CHECK,  32'h0,  32'h0,         32'hFFFF_FFFF, 1'b0, 1'b1);
        send_item(paft_pkg::FUNC_ADD,    32'h5,  32'hFFFF_FFFF, 32'h0,         1'b0, 1'b1);
        send_item(paft_pkg::FUNC_REMOVE, 32'h5,  32'h0,         32'h0,         1'b0, 1'b1);
        send_item(paft_pkg::FUNC_CLEAR,  32'h0,  32'h0,         32'h0,         1'b0, 1'b0);
        set_filter(1'b1);
        send_item(paft_pkg::FUNC_CHECK,  32'h5,  32'h0,         32'h1234_5678, 1'b0, 1'b1);
        send_item(paft_pkg::FUNC_ADD,    32'h0,  32'hFFFF_FFFF, 32'h0,         1'b0, 1'b0);
        send_item(paft_pkg::FUNC_ADD,    32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0,  1'b1, 1'b1);
        send_item(paft_pkg::FUNC_ADD,    32'h5,  32'hA5A5_A5A5, 32'h0,         1'b0, 1'b1);
        send_item(paft_pkg::FUNC_CHECK,  32'h0,  32'h0,         32'hFFFF_FFFF, 1'b0, 1'b1);
        send_item(paft_pkg::FUNC_CHECK,  32'hFFFF_FFFF, 32'h0,  32'hFFFF_FFFF, 1'b0, 1'b1);
        // A kernel request on a held id hits but keeps its access.
        send_item(paft_pkg::FUNC_CHECK,  32'h5,  32'h0,         32'hFFFF_FFFF, 1'b1, 1'b1);
        // A non-process object is never matched.
        send_item(paft_pkg::FUNC_CHECK,  32'h5,  32'h0,         32'hFFFF_FFFF, 1'b0, 1'b0);
        send_item(paft_pkg::FUNC_ADD,    32'h5,  32'h0F0F_0F0F, 32'h0,         1'b0, 1'b1);
        send_item(paft_pkg::FUNC_CHECK,  32'h5,  32'h0,         32'hFFFF_FFFF, 1'b0, 1'b1);
        send_item(paft_pkg::FUNC_REMOVE, 32'h0,  32'h0,         32'h0,         1'b0, 1'b1);
        send_item(paft_pkg::FUNC_REMOVE, 32'h0,  32'h0,         32'h0,         1'b0, 1'b1);
        send_item(paft_pkg::FUNC_CHECK,  32'h0,  32'h0,         32'hFFFF_FFFF, 1'b0, 1'b1);
        send_item(paft_pkg::FUNC_CLEAR,  32'h0,  32'h0,         32'h0,         1'b1, 1'b1);
        send_item(paft_pkg::FUNC_CHECK,  32'hFFFF_FFFF, 32'h0,  32'hFFFF_FFFF, 1'b0, 1'b1);
        send_item(paft_pkg::FUNC_REMOVE, 32'hFFFF_FFFF, 32'h0,  32'h0,         1'b0, 1'b1);
        send_item(paft_pkg::FUNC_ADD,    32'h7,  32'hFFFF_0000, 32'h0,         1'b0, 1'b1);
        // Entries survive a disable but are not matched until re-enabled.
        set_filter(1'b0);
        send_item(paft_pkg::FUNC_CHECK,  32'h7,  32'h0,         32'hFFFF_FFFF, 1'b0, 1'b1);
        set_filter(1'b1);
        send_item(paft_pkg::FUNC_CHECK,  32'h7,  32'h0,         32'hFFFF_FFFF, 1'b0, 1'b1);

        phase = 0;
        while (sent < ITEMS)
        begin
            calm = (phase == 3);
            if (phase > 0 && chance(20))
                set_filter(chance(80));
            if (phase % 7 == 2)
            begin
                if (!board.enabled)
                    set_filter(1'b1);
                fill_table();
            end
            else if (phase == 5)
            begin
                // The receiver holds off while the sender keeps offering back to back.
                calm      = 1'b1;
                hold_left = 300;
                run_mix(40, 20, 50, 30, 17);
            end
            else
                run_mix($urandom_range(20, 60), (phase % 3 == 0) ? POOL : 20, 45, 30, 22);
            if (phase == 8)
            begin
                in_stop();
                wait_drained();
            end
            phase++;
        end
        calm = 1'b0;

        in_stop();
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        $display("Sent %0d items (%0d checks, %0d adds, %0d removes, %0d clears), %0d results.",
                 sent, board.ops_seen[paft_pkg::FUNC_CHECK], board.ops_seen[paft_pkg::FUNC_ADD],
                 board.ops_seen[paft_pkg::FUNC_REMOVE], board.ops_seen[paft_pkg::FUNC_CLEAR],
                 board.results_seen);
        $display("Saw %0d hits, %0d full tables, %0d missing ids, %0d enable writes.",
                 board.hits_seen, board.full_seen, board.missing_seen, cfg_writes);
        if (board.errors == 0 && board.pending_verdicts.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/paft_pkg.sv
design/paft_ram.sv
design/paft_ctrl.sv
design/paft_dpath.sv
design/pid_access_filter_table_unit.sv
bench/pid_access_filter_table_unit_tb.sv
